// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the response point evaluator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BRPE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BRPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/brpe_pkg.sv
// ---------------------------------------------------------------------------
// brpe_pkg
// Widths, register codes and shared types of the response point evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package brpe_pkg;

    // Field widths
    localparam int COEF_W    = 32;          // Q4.28 coefficients
    localparam int Z_W       = 32;          // Q2.30 point
    localparam int H_W       = 48;          // Q16.32 response
    localparam int CFG_IDX_W = 3;

    // Internal widths
    localparam int ND_W    = 37;            // numerator / denominator, Q28
    localparam int H_SPLIT = 24;            // low chunk of H for H*N partials
    localparam int PHN_W   = 62;            // H*N partial product
    localparam int HN_W    = 86;            // H*N, Q60
    localparam int C_W     = 29;            // chunk of H*N for P partials
    localparam int PP_W    = 67;            // P partial product
    localparam int P_W     = 124;           // H*N*conj(D), Q88
    localparam int DEN_W   = 74;            // |D|^2, Q56
    localparam int Q_W     = 48;            // quotient bits before rounding
    localparam int DIV_LAT = Q_W + 2;       // divider latency

    // Register codes
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RST  = 32'sh1000_0000;
    localparam logic signed [ND_W-1:0]   ONE_Q28 = ND_W'(64'sd1 <<< 28);

    // Saturation magnitudes
    localparam logic [Q_W:0] MAG_POS = (Q_W+1)'((64'd1 << (H_W-1)) - 64'd1);
    localparam logic [Q_W:0] MAG_NEG = (Q_W+1)'(64'd1 << (H_W-1));

    // Divider result
    typedef struct packed {
        logic [Q_W:0] quo;
        logic         ovf;
    } t_div_res;

    // Per-item control carried alongside the divider
    typedef struct packed {
        logic last;
        logic dz;
        logic hnr_neg;
        logic hnr_nz;
        logic hni_neg;
        logic hni_nz;
        logic pr_neg;
        logic pi_neg;
    } t_side;

endpackage

`default_nettype wire

// File: sv/biquad_response_point_eval_unit.sv
// Pipeline: 10 datapath stages, 50 divider stages and 1 output register lie
//   between an accepted item and its result.
// Throughput: one item per cycle unless the output stalls; the 48-stage quotient
// pipeline sets the depth. A stall at the output freezes every stage at once; nothing is dropped.
// Reset (synchronous, active low) clears valid bits and loads the coefficient
//   registers with b0 = 1.0 and all others 0.
// ---------------------------------------------------------------------------
// biquad_response_point_eval_unit
// Evaluates H * N(Z) / D(Z) for one complex point per item, with saturation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module biquad_response_point_eval_unit (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_cfg_we,
    input  wire logic [brpe_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  wire logic [brpe_pkg::COEF_W-1:0]                i_cfg_data,
    input  wire logic                                       i_in_valid,
    output      logic                                       o_in_stall,
    input  wire logic signed [brpe_pkg::Z_W-1:0]            i_point_re,
    input  wire logic signed [brpe_pkg::Z_W-1:0]            i_point_im,
    input  wire logic signed [brpe_pkg::H_W-1:0]            i_resp_re_in,
    input  wire logic signed [brpe_pkg::H_W-1:0]            i_resp_im_in,
    input  wire logic                                       i_last_in,
    output      logic                                       o_out_valid,
    input  wire logic                                       i_out_stall,
    output      logic signed [brpe_pkg::H_W-1:0]            o_resp_re_out,
    output      logic signed [brpe_pkg::H_W-1:0]            o_resp_im_out,
    output      logic                                       o_clipped,
    output      logic                                       o_last_out
);

    localparam int CW  = brpe_pkg::COEF_W;
    localparam int HW  = brpe_pkg::H_W;
    localparam int NDW = brpe_pkg::ND_W;
    localparam int HNW = brpe_pkg::HN_W;
    localparam int PW  = brpe_pkg::P_W;
    localparam int QW  = brpe_pkg::Q_W;
    localparam int DL  = brpe_pkg::DIV_LAT;
    localparam int HS  = brpe_pkg::H_SPLIT;
    localparam int CK  = brpe_pkg::C_W;

    // Coefficient registers
    logic signed [CW-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= brpe_pkg::B0_RST;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                brpe_pkg::REG_B0: r_b0 <= $signed(i_cfg_data);
                brpe_pkg::REG_B1: r_b1 <= $signed(i_cfg_data);
                brpe_pkg::REG_B2: r_b2 <= $signed(i_cfg_data);
                brpe_pkg::REG_A1: r_a1 <= $signed(i_cfg_data);
                brpe_pkg::REG_A2: r_a2 <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves unless the output item is held
    logic w_adv;
    logic r_vo;
    assign w_adv      = !(r_vo && i_out_stall);
    assign o_in_stall = !w_adv;

    // Valid bits of the datapath stages
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;
    logic r_dvld [DL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10} <= '0;
            for (int k = 0; k < DL; k++) r_dvld[k] <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_adv) begin
            r_v1  <= i_in_valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_dvld[0] <= r_v10;
            for (int k = 1; k < DL; k++) r_dvld[k] <= r_dvld[k-1];
            r_vo <= r_dvld[DL-1];
        end
    end

    // Stage 1: products of Z and first-order coefficients
    logic signed [63:0]   r1_zrr, r1_zii, r1_zri, r1_b1r, r1_b1i, r1_a1r, r1_a1i;
    logic signed [HW-1:0] r1_hr, r1_hi;
    logic                 r1_last;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_zrr  <= i_point_re * i_point_re;
            r1_zii  <= i_point_im * i_point_im;
            r1_zri  <= i_point_re * i_point_im;
            r1_b1r  <= r_b1 * i_point_re;
            r1_b1i  <= r_b1 * i_point_im;
            r1_a1r  <= r_a1 * i_point_re;
            r1_a1i  <= r_a1 * i_point_im;
            r1_hr   <= i_resp_re_in;
            r1_hi   <= i_resp_im_in;
            r1_last <= i_last_in;
        end
    end

    // Stage 2: Z^2 and first-order terms, rounded to Q28
    logic signed [64:0] n2_zd;
    logic signed [63:0] n2_zi, n2_b1r, n2_b1i, n2_a1r, n2_a1i;
    logic signed [31:0] r2_z2r;
    logic signed [32:0] r2_z2i;
    logic signed [33:0] r2_b1r, r2_b1i, r2_a1r, r2_a1i;
    logic signed [HW-1:0] r2_hr, r2_hi;
    logic                 r2_last;

    always_comb begin
        n2_zd  = 65'(r1_zrr) - 65'(r1_zii) + 65'sh8000_0000;
        n2_zi  = r1_zri + 64'sh4000_0000;
        n2_b1r = r1_b1r + 64'sh2000_0000;
        n2_b1i = r1_b1i + 64'sh2000_0000;
        n2_a1r = r1_a1r + 64'sh2000_0000;
        n2_a1i = r1_a1i + 64'sh2000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_z2r  <= $signed(n2_zd[63:32]);
            r2_z2i  <= $signed(n2_zi[63:31]);
            r2_b1r  <= $signed(n2_b1r[63:30]);
            r2_b1i  <= $signed(n2_b1i[63:30]);
            r2_a1r  <= $signed(n2_a1r[63:30]);
            r2_a1i  <= $signed(n2_a1i[63:30]);
            r2_hr   <= r1_hr;
            r2_hi   <= r1_hi;
            r2_last <= r1_last;
        end
    end

    // Stage 3: second-order products
    logic signed [63:0] r3_b2r, r3_a2r;
    logic signed [64:0] r3_b2i, r3_a2i;
    logic signed [33:0] r3_b1r, r3_b1i, r3_a1r, r3_a1i;
    logic signed [HW-1:0] r3_hr, r3_hi;
    logic                 r3_last;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_b2r  <= r_b2 * r2_z2r;
            r3_a2r  <= r_a2 * r2_z2r;
            r3_b2i  <= r_b2 * r2_z2i;
            r3_a2i  <= r_a2 * r2_z2i;
            r3_b1r  <= r2_b1r;
            r3_b1i  <= r2_b1i;
            r3_a1r  <= r2_a1r;
            r3_a1i  <= r2_a1i;
            r3_hr   <= r2_hr;
            r3_hi   <= r2_hi;
            r3_last <= r2_last;
        end
    end

    // Stage 4: N and D at Q28
    logic signed [63:0]  n4_b2r, n4_a2r;
    logic signed [64:0]  n4_b2i, n4_a2i;
    logic signed [NDW-1:0] n4_b2rr, n4_a2rr, n4_b2ir, n4_a2ir;
    logic signed [NDW-1:0] r4_nr, r4_ni, r4_dr, r4_di;
    logic signed [HW-1:0]  r4_hr, r4_hi;
    logic                  r4_last;

    always_comb begin
        n4_b2r  = r3_b2r + 64'sh800_0000;
        n4_a2r  = r3_a2r + 64'sh800_0000;
        n4_b2i  = r3_b2i + 65'sh800_0000;
        n4_a2i  = r3_a2i + 65'sh800_0000;
        n4_b2rr = NDW'($signed(n4_b2r[63:28]));
        n4_a2rr = NDW'($signed(n4_a2r[63:28]));
        n4_b2ir = $signed(n4_b2i[64:28]);
        n4_a2ir = $signed(n4_a2i[64:28]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_nr   <= NDW'(r_b0) + NDW'(r3_b1r) + n4_b2rr;
            r4_ni   <= NDW'(r3_b1i) + n4_b2ir;
            r4_dr   <= brpe_pkg::ONE_Q28 - NDW'(r3_a1r) - n4_a2rr;
            r4_di   <= -NDW'(r3_a1i) - n4_a2ir;
            r4_hr   <= r3_hr;
            r4_hi   <= r3_hi;
            r4_last <= r3_last;
        end
    end

    // Stage 5: H*N partial products (H split in two) and |D|^2 squares
    logic signed [brpe_pkg::PHN_W-1:0] r5_rr_h, r5_rr_l, r5_ii_h, r5_ii_l;
    logic signed [brpe_pkg::PHN_W-1:0] r5_ri_h, r5_ri_l, r5_ir_h, r5_ir_l;
    logic signed [2*NDW-1:0] r5_drsq, r5_disq;
    logic signed [NDW-1:0]   r5_dr, r5_di;
    logic                    r5_last;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_rr_h <= $signed(r4_hr[HW-1:HS]) * r4_nr;
            r5_rr_l <= $signed({1'b0, r4_hr[HS-1:0]}) * r4_nr;
            r5_ii_h <= $signed(r4_hi[HW-1:HS]) * r4_ni;
            r5_ii_l <= $signed({1'b0, r4_hi[HS-1:0]}) * r4_ni;
            r5_ri_h <= $signed(r4_hr[HW-1:HS]) * r4_ni;
            r5_ri_l <= $signed({1'b0, r4_hr[HS-1:0]}) * r4_ni;
            r5_ir_h <= $signed(r4_hi[HW-1:HS]) * r4_nr;
            r5_ir_l <= $signed({1'b0, r4_hi[HS-1:0]}) * r4_nr;
            r5_drsq <= r4_dr * r4_dr;
            r5_disq <= r4_di * r4_di;
            r5_dr   <= r4_dr;
            r5_di   <= r4_di;
            r5_last <= r4_last;
        end
    end

    // Stage 6: H*N and |D|^2
    logic signed [HNW-1:0] n6_rr, n6_ii, n6_ri, n6_ir;
    logic signed [HNW-1:0] r6_hnr, r6_hni;
    logic [brpe_pkg::DEN_W-1:0] r6_den;
    logic signed [NDW-1:0] r6_dr, r6_di;
    logic                  r6_last;

    always_comb begin
        n6_rr = (HNW'(r5_rr_h) <<< HS) + HNW'(r5_rr_l);
        n6_ii = (HNW'(r5_ii_h) <<< HS) + HNW'(r5_ii_l);
        n6_ri = (HNW'(r5_ri_h) <<< HS) + HNW'(r5_ri_l);
        n6_ir = (HNW'(r5_ir_h) <<< HS) + HNW'(r5_ir_l);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_hnr  <= n6_rr - n6_ii;
            r6_hni  <= n6_ri + n6_ir;
            r6_den  <= brpe_pkg::DEN_W'($unsigned(r5_drsq))
                     + brpe_pkg::DEN_W'($unsigned(r5_disq));
            r6_dr   <= r5_dr;
            r6_di   <= r5_di;
            r6_last <= r5_last;
        end
    end

    // Stage 7: (H*N) * D partial products, H*N in three chunks
    logic signed [brpe_pkg::PP_W-1:0] r7_p [4][3];
    logic [brpe_pkg::DEN_W-1:0] r7_den;
    brpe_pkg::t_side            r7_side;
    logic signed [HNW-1:0]      n7_a [4];
    logic signed [NDW-1:0]      n7_b [4];

    // product order: hnr*dr, hni*di, hni*dr, hnr*di
    always_comb begin
        n7_a[0] = r6_hnr; n7_b[0] = r6_dr;
        n7_a[1] = r6_hni; n7_b[1] = r6_di;
        n7_a[2] = r6_hni; n7_b[2] = r6_dr;
        n7_a[3] = r6_hnr; n7_b[3] = r6_di;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int m = 0; m < 4; m++) begin
                r7_p[m][0] <= $signed({1'b0, n7_a[m][CK-1:0]}) * n7_b[m];
                r7_p[m][1] <= $signed({1'b0, n7_a[m][2*CK-1:CK]}) * n7_b[m];
                r7_p[m][2] <= $signed(n7_a[m][HNW-1:2*CK]) * n7_b[m];
            end
            r7_den          <= r6_den;
            r7_side.last    <= r6_last;
            r7_side.dz      <= (r6_den == '0);
            r7_side.hnr_neg <= r6_hnr[HNW-1];
            r7_side.hnr_nz  <= |r6_hnr;
            r7_side.hni_neg <= r6_hni[HNW-1];
            r7_side.hni_nz  <= |r6_hni;
            r7_side.pr_neg  <= 1'b0;
            r7_side.pi_neg  <= 1'b0;
        end
    end

    // Stage 8: sum chunks of each product
    logic signed [PW-1:0] r8_q [4];
    logic [brpe_pkg::DEN_W-1:0] r8_den;
    brpe_pkg::t_side            r8_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int m = 0; m < 4; m++) begin
                r8_q[m] <= (PW'(r7_p[m][2]) <<< (2*CK)) + (PW'(r7_p[m][1]) <<< CK)
                         + PW'(r7_p[m][0]);
            end
            r8_den  <= r7_den;
            r8_side <= r7_side;
        end
    end

    // Stage 9: P = H*N*conj(D)
    logic signed [PW-1:0] r9_pr, r9_pi;
    logic [brpe_pkg::DEN_W-1:0] r9_den;
    brpe_pkg::t_side            r9_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_pr   <= r8_q[0] + r8_q[1];
            r9_pi   <= r8_q[2] - r8_q[3];
            r9_den  <= r8_den;
            r9_side <= r8_side;
        end
    end

    // Stage 10: magnitudes and signs for the dividers
    logic [PW-1:0] r_pm_re, r_pm_im;
    logic [brpe_pkg::DEN_W-1:0] r10_den;
    brpe_pkg::t_side            r10_side;
    brpe_pkg::t_side            n10_side;

    always_comb begin
        n10_side        = r9_side;
        n10_side.pr_neg = r9_pr[PW-1];
        n10_side.pi_neg = r9_pi[PW-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pm_re         <= r9_pr[PW-1] ? $unsigned(-r9_pr) : $unsigned(r9_pr);
            r_pm_im         <= r9_pi[PW-1] ? $unsigned(-r9_pi) : $unsigned(r9_pi);
            r10_den         <= r9_den;
            r10_side        <= n10_side;
        end
    end

    // Dividers, one per part
    brpe_pkg::t_div_res w_div_re, w_div_im;

    brpe_div u_div_re (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_pm_re),
        .i_den (r10_den),
        .o_res (w_div_re)
    );

    brpe_div u_div_im (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_pm_im),
        .i_den (r10_den),
        .o_res (w_div_im)
    );

    // Control bits alongside the dividers
    brpe_pkg::t_side r_side [DL];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= r10_side;
            for (int k = 1; k < DL; k++) r_side[k] <= r_side[k-1];
        end
    end

    // Saturate a rounded magnitude and apply the sign: {clip, value}
    function automatic logic [HW:0] sat_part(input logic [QW:0] quo,
                                             input logic ovf,
                                             input logic neg);
        logic [QW:0] lim;
        logic [QW:0] mag;
        logic [QW:0] sv;
        logic        over;
        lim  = neg ? brpe_pkg::MAG_NEG : brpe_pkg::MAG_POS;
        over = ovf || (quo > lim);
        mag  = over ? lim : quo;
        sv   = neg ? -mag : mag;
        return {over, sv[HW-1:0]};
    endfunction

    // Zero denominator: full scale with the sign of H*N, or zero where H*N is zero
    function automatic logic [HW-1:0] sign_sat(input logic neg, input logic nz);
        logic [HW-1:0] v;
        v = '0;
        if (nz) v = neg ? HW'(brpe_pkg::MAG_NEG) : HW'(brpe_pkg::MAG_POS);
        return v;
    endfunction

    // Output stage
    brpe_pkg::t_side n_so;
    logic [HW:0]     n_re, n_im;
    logic signed [HW-1:0] r_o_re, r_o_im;
    logic r_o_clip, r_o_last;

    always_comb begin
        n_so = r_side[DL-1];
        n_re = sat_part(w_div_re.quo, w_div_re.ovf, n_so.pr_neg);
        n_im = sat_part(w_div_im.quo, w_div_im.ovf, n_so.pi_neg);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (n_so.dz) begin
                r_o_re   <= $signed(sign_sat(n_so.hnr_neg, n_so.hnr_nz));
                r_o_im   <= $signed(sign_sat(n_so.hni_neg, n_so.hni_nz));
                r_o_clip <= 1'b1;
            end else begin
                r_o_re   <= $signed(n_re[HW-1:0]);
                r_o_im   <= $signed(n_im[HW-1:0]);
                r_o_clip <= n_re[HW] | n_im[HW];
            end
            r_o_last <= n_so.last;
        end
    end

    assign o_out_valid   = r_vo;
    assign o_resp_re_out = r_o_re;
    assign o_resp_im_out = r_o_im;
    assign o_clipped     = r_o_clip;
    assign o_last_out    = r_o_last;

    // Checks
    `BRPE_ASSERT_IMPLY(a_pmag_fits, i_clk, i_rst_n, r_v10, !r_pm_re[PW-1] && !r_pm_im[PW-1], "P magnitude reached the top bit")
    `BRPE_ASSERT_NEXT(a_hold_freezes, i_clk, i_rst_n, !w_adv, r_vo && $stable(r_side[DL-1]) && $stable(r_v10), "pipeline moved during a hold")
    `BRPE_ASSERT_NEXT(a_dz_clips, i_clk, i_rst_n, w_adv && r_dvld[DL-1] && r_side[DL-1].dz, o_out_valid && o_clipped, "zero denominator item left unclipped")

endmodule

`default_nettype wire

// File: sv/brpe_div.sv
// ---------------------------------------------------------------------------
// brpe_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detection at or above 2^48 and round-half-up of the quotient.
// ---------------------------------------------------------------------------
`default_nettype none

module brpe_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [brpe_pkg::P_W-1:0]         i_num,
    input  wire logic [brpe_pkg::DEN_W-1:0]       i_den,
    output      brpe_pkg::t_div_res               o_res
);

    localparam int QW = brpe_pkg::Q_W;
    localparam int DW = brpe_pkg::DEN_W;

    logic [DW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_nlo [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_ovf [QW+1];
    brpe_pkg::t_div_res r_res;

    // Entry: overflow check and initial partial remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= i_num >= brpe_pkg::P_W'({i_den, {QW{1'b0}}});
            r_rem[0] <= i_num[QW +: DW];
            r_nlo[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0]   n_try;
        logic [DW:0]   n_diff;
        logic          n_ge;
        logic [DW-1:0] n_rem;

        always_comb begin
            n_try  = {r_rem[k], r_nlo[k][QW-1]};
            n_diff = n_try - {1'b0, r_den[k]};
            n_ge   = n_try >= {1'b0, r_den[k]};
            n_rem  = n_ge ? n_diff[DW-1:0] : n_try[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_nlo[k+1] <= r_nlo[k] << 1;
                r_quo[k+1] <= {r_quo[k][QW-2:0], n_ge};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    // Round to nearest, ties up on the magnitude
    logic n_up;
    assign n_up = {r_rem[QW], 1'b0} >= {1'b0, r_den[QW]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.quo <= {1'b0, r_quo[QW]} + (QW+1)'(n_up);
            r_res.ovf <= r_ovf[QW];
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
